>>> design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared constants, controller states and the controller command bundle.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int DATA_WIDTH_DEF = 64;
	localparam int KEY_W          = 32;
	localparam int WORD_W         = 64;
	localparam int CAP_W          = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic lookup;
		logic update;
	} cmd_t;

endpackage

>>> design/lkvc_req_if.sv
// ----------------------------------------------------------------------------
// LRU key-value cache request channel
// Valid/ready channel that carries one get or put request.
// ----------------------------------------------------------------------------
interface lkvc_req_if;

	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic signed [lkvc_pkg::KEY_W-1:0] key;
	logic [lkvc_pkg::WORD_W-1:0]      write_data;

	modport source (output valid, output opcode, output key, output write_data, input ready);
	modport sink (input valid, input opcode, input key, input write_data, output ready);

endinterface

>>> design/lkvc_rsp_if.sv
// ----------------------------------------------------------------------------
// LRU key-value cache response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if;

	logic                             valid;
	logic                             ready;
	logic                             hit;
	logic [lkvc_pkg::WORD_W-1:0]      read_data;
	logic                             evicted;
	logic signed [lkvc_pkg::KEY_W-1:0] evicted_key;

	modport source (output valid, output hit, output read_data, output evicted,
		output evicted_key, input ready);
	modport sink (input valid, input hit, input read_data, input evicted,
		input evicted_key, output ready);

endinterface

>>> design/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences lookup and update of one request and owns the result valid flag.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output lkvc_pkg::cmd_t   cmd
);

	lkvc_pkg::state_t state_q;
	lkvc_pkg::state_t state_next;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		in_ready = (state_q == lkvc_pkg::ST_IDLE) ||
			((state_q == lkvc_pkg::ST_UPDATE) && out_free);
		accept         = in_valid && in_ready;
		cmd.load_in    = accept;
		cmd.lookup     = (state_q == lkvc_pkg::ST_LOOKUP);
		cmd.update     = (state_q == lkvc_pkg::ST_UPDATE) && out_free;
	end

	always_comb begin
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				state_next = (in_valid) ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
			end
			lkvc_pkg::ST_LOOKUP: begin
				state_next = lkvc_pkg::ST_UPDATE;
			end
			lkvc_pkg::ST_UPDATE: begin
				if (!out_free) begin
					state_next = lkvc_pkg::ST_UPDATE;
				end else if (in_valid) begin
					state_next = lkvc_pkg::ST_LOOKUP;
				end else begin
					state_next = lkvc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkvc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Entry register file, parallel key compare, recency ranks and result register.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
	parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
	parameter int DATA_WIDTH = lkvc_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lkvc_pkg::cmd_t                     cmd,
	input  logic                               opcode,
	input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
	input  logic [lkvc_pkg::WORD_W-1:0]        write_data,
	input  logic                               cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                               hit,
	output logic [lkvc_pkg::WORD_W-1:0]        read_data,
	output logic                               evicted,
	output logic signed [lkvc_pkg::KEY_W-1:0]  evicted_key
);

	localparam int RANK_W = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	logic                          op_q;
	logic [lkvc_pkg::KEY_W-1:0]    key_q;
	logic [DATA_WIDTH-1:0]         wdata_q;
	logic [lkvc_pkg::CAP_W-1:0]    capacity_q;

	logic [lkvc_pkg::KEY_W-1:0]    entry_key_q  [ENTRIES];
	logic [DATA_WIDTH-1:0]         entry_data_q [ENTRIES];
	logic [ENTRIES-1:0]            entry_valid_q;
	logic [RANK_W-1:0]             rank_q       [ENTRIES];
	logic [CNT_W-1:0]              count_q;

	logic [CMP_W-1:0]              cap_ext;
	logic [CMP_W-1:0]              eff_cap;
	logic                          need_evict;
	logic [RANK_W-1:0]             last_rank;
	logic [ENTRIES-1:0]            match;
	logic [ENTRIES-1:0]            victim;
	logic [ENTRIES-1:0]            avail;
	logic [ENTRIES-1:0]            free_slot;
	logic                          found;
	logic [RANK_W-1:0]             hit_rank;
	logic [DATA_WIDTH-1:0]         rd_data;
	logic [lkvc_pkg::KEY_W-1:0]    vic_key;

	logic [ENTRIES-1:0]            match_s1;
	logic [ENTRIES-1:0]            victim_s1;
	logic [ENTRIES-1:0]            free_s1;
	logic                          hit_s1;
	logic                          evict_s1;
	logic [RANK_W-1:0]             hit_rank_s1;
	logic [DATA_WIDTH-1:0]         rd_s1;
	logic [lkvc_pkg::KEY_W-1:0]    vic_key_s1;

	logic                          put_miss;

	logic                          hit_q;
	logic [lkvc_pkg::WORD_W-1:0]   read_data_q;
	logic                          evicted_q;
	logic [lkvc_pkg::KEY_W-1:0]    evicted_key_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= opcode;
			key_q   <= key;
			wdata_q <= write_data[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// The valid ranks are always 0 .. count-1, so the least recent entry is
	// the one whose rank equals count-1.
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		need_evict = CMP_W'(count_q) >= eff_cap;
		last_rank  = RANK_W'(count_q - CNT_W'(1));
		hit_rank   = '0;
		rd_data    = '0;
		vic_key    = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = entry_valid_q[i] && (entry_key_q[i] == key_q);
			victim[i] = entry_valid_q[i] && (count_q != '0) && (rank_q[i] == last_rank);
			hit_rank  = hit_rank | (match[i] ? rank_q[i] : '0);
			rd_data   = rd_data | (match[i] ? entry_data_q[i] : '0);
			vic_key   = vic_key | (victim[i] ? entry_key_q[i] : '0);
		end
		avail = ~entry_valid_q | (need_evict ? victim : '0);
		found = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			free_slot[i] = avail[i] && !found;
			found        = found | avail[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			match_s1    <= match;
			victim_s1   <= victim;
			free_s1     <= free_slot;
			hit_s1      <= |match;
			evict_s1    <= need_evict;
			hit_rank_s1 <= hit_rank;
			rd_s1       <= rd_data;
			vic_key_s1  <= vic_key;
		end
	end

	assign put_miss = !hit_s1 && (op_q == lkvc_pkg::OP_PUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			count_q       <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.update) begin
			if (hit_s1) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (match_s1[i]) begin
						rank_q[i] <= '0;
					end else if (entry_valid_q[i] && (rank_q[i] < hit_rank_s1)) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end else if (put_miss) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (free_s1[i]) begin
						entry_valid_q[i] <= 1'b1;
						rank_q[i]        <= '0;
					end else if (evict_s1 && victim_s1[i]) begin
						entry_valid_q[i] <= 1'b0;
						rank_q[i]        <= '0;
					end else if (entry_valid_q[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
				if (!evict_s1) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (hit_s1 && (op_q == lkvc_pkg::OP_PUT) && match_s1[i]) begin
					entry_data_q[i] <= wdata_q;
				end else if (put_miss && free_s1[i]) begin
					entry_key_q[i]  <= key_q;
					entry_data_q[i] <= wdata_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q         <= hit_s1;
			read_data_q   <= (hit_s1 && (op_q == lkvc_pkg::OP_GET)) ?
				lkvc_pkg::WORD_W'(rd_s1) : '0;
			evicted_q     <= put_miss && evict_s1;
			evicted_key_q <= (put_miss && evict_s1) ? vic_key_s1 : '0;
		end
	end

	assign hit         = hit_q;
	assign read_data   = read_data_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

>>> design/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request has a lookup state, to compare the key against all entries at
// once and find the least recent entry, and an update state, to update the
// recency ranks, write the entry and load the result register. The next
// request is taken in the update state, and no sooner; a result not taken
// holds the block there until the response transfer completes. Capacity is
// to be written by the user only while idle; the block does not enforce it.
module lru_key_value_cache_top #(
	parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
	parameter int DATA_WIDTH = lkvc_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lkvc_req_if.sink                   req,
	lkvc_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);

	lkvc_pkg::cmd_t cmd;

	lkvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	lkvc_datapath #(
		.ENTRIES    (ENTRIES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (req.opcode),
		.key         (req.key),
		.write_data  (req.write_data),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.hit         (rsp.hit),
		.read_data   (rsp.read_data),
		.evicted     (rsp.evicted),
		.evicted_key (rsp.evicted_key)
	);

endmodule

>>> design/lkvc_checker.sv
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module lkvc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_hit,
	input logic [lkvc_pkg::WORD_W-1:0] rsp_read_data,
	input logic                        rsp_evicted,
	input logic [lkvc_pkg::KEY_W-1:0]  rsp_evicted_key
);

	a_no_evict_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_hit && rsp_evicted))
		else $error("eviction reported together with a hit");

	a_evicted_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_evicted) |-> (rsp_evicted_key == '0))
		else $error("evicted key not zero without an eviction");

	a_miss_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_hit) |-> (rsp_read_data == '0))
		else $error("read data not zero on a miss");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> ##3 rsp_valid)
		else $error("no result after an accepted request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit) &&
		$stable(rsp_read_data) && $stable(rsp_evicted) && $stable(rsp_evicted_key)))
		else $error("stalled result changed");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_hit         (rsp.hit),
	.rsp_read_data   (rsp.read_data),
	.rsp_evicted     (rsp.evicted),
	.rsp_evicted_key (rsp.evicted_key)
);
